FILE: rtl/core/ntf_pkg.sv
// Shared types, constants and the control program of the number-to-text formatter.
// No dependencies; every other file of the block but ntf_rsp_if imports this package.
`default_nettype none

package ntf_pkg;

   localparam int WORD_W = 64;
   localparam int DIGITS = 20;
   localparam int BCD_W = 4 * DIGITS;
   localparam int CNT_W = 7;
   localparam int STEP_W = 4;
   localparam int ADDR_W = 4;
   localparam int DATA_W = 32;

   localparam logic [1:0] RADIX_BIN = 2'd0;
   localparam logic [1:0] RADIX_DEC = 2'd1;
   localparam logic [1:0] RADIX_HEX = 2'd2;

   localparam logic [1:0] REG_RADIX = 2'd0;
   localparam logic [1:0] REG_WORD_SIZE = 2'd1;
   localparam logic [1:0] REG_SIGNED = 2'd2;
   localparam logic [1:0] REG_GROUP = 2'd3;

   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_ONE = 8'h31;
   localparam logic [7:0] CHAR_COMMA = 8'h2c;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_ALPHA_BASE = 8'h57;

   localparam logic [CNT_W-1:0] DIGIT_COUNT = CNT_W'(DIGITS);
   localparam logic [1:0] TOP_DIGIT_MOD3 = 2'((DIGITS - 1) % 3);

   typedef logic [STEP_W-1:0] step_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_ACCEPT,
      OP_EMIT_WORD,
      OP_NEGATE,
      OP_DABBLE,
      OP_DIGITS_INIT,
      OP_SKIP,
      OP_EMIT_SIGN,
      OP_EMIT_DIGIT,
      OP_EMIT_COMMA
   } op_type;

   typedef enum logic [2:0] {
      C_NONE,
      C_ALWAYS,
      C_BAD_RADIX,
      C_DECIMAL,
      C_MORE,
      C_LEAD_ZERO,
      C_COMMA,
      C_DIGITS_LEFT
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ctrl_type;

   typedef struct packed {
      logic done;
      logic bad_radix;
      logic decimal;
      logic more;
      logic lead_zero;
      logic comma;
      logic digits_left;
   } flags_type;

   localparam step_type ST_IDLE = 4'd0;
   localparam step_type ST_SPLIT = 4'd1;
   localparam step_type ST_EMIT_WORD = 4'd2;
   localparam step_type ST_WORD_END = 4'd3;
   localparam step_type ST_NEGATE = 4'd4;
   localparam step_type ST_DABBLE = 4'd5;
   localparam step_type ST_DIGITS_INIT = 4'd6;
   localparam step_type ST_SKIP = 4'd7;
   localparam step_type ST_SIGN = 4'd8;
   localparam step_type ST_DIGIT = 4'd9;
   localparam step_type ST_DIGIT_NEXT = 4'd10;
   localparam step_type ST_DIGIT_END = 4'd11;
   localparam step_type ST_COMMA = 4'd12;

   function automatic ctrl_type program_word(input step_type pc);
      ctrl_type w;
      unique case (pc)
         ST_IDLE:        w = '{OP_ACCEPT,      C_BAD_RADIX,   ST_IDLE};
         ST_SPLIT:       w = '{OP_NOP,         C_DECIMAL,     ST_NEGATE};
         ST_EMIT_WORD:   w = '{OP_EMIT_WORD,   C_MORE,        ST_EMIT_WORD};
         ST_WORD_END:    w = '{OP_NOP,         C_ALWAYS,      ST_IDLE};
         ST_NEGATE:      w = '{OP_NEGATE,      C_NONE,        ST_IDLE};
         ST_DABBLE:      w = '{OP_DABBLE,      C_MORE,        ST_DABBLE};
         ST_DIGITS_INIT: w = '{OP_DIGITS_INIT, C_NONE,        ST_IDLE};
         ST_SKIP:        w = '{OP_SKIP,        C_LEAD_ZERO,   ST_SKIP};
         ST_SIGN:        w = '{OP_EMIT_SIGN,   C_NONE,        ST_IDLE};
         ST_DIGIT:       w = '{OP_EMIT_DIGIT,  C_COMMA,       ST_COMMA};
         ST_DIGIT_NEXT:  w = '{OP_NOP,         C_DIGITS_LEFT, ST_DIGIT};
         ST_DIGIT_END:   w = '{OP_NOP,         C_ALWAYS,      ST_IDLE};
         ST_COMMA:       w = '{OP_EMIT_COMMA,  C_ALWAYS,      ST_DIGIT};
         default:        w = '{OP_NOP,         C_ALWAYS,      ST_IDLE};
      endcase
      return w;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] c;
      if (nib < 4'd10) begin
         c = CHAR_ZERO + {4'b0, nib};
      end else begin
         c = CHAR_ALPHA_BASE + {4'b0, nib};
      end
      return c;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/ntf_req_if.sv
// Input channel of the formatter: one register value per beat.
// Depends on ntf_pkg for the word width.
`default_nettype none

interface ntf_req_if;
   import ntf_pkg::*;

   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/ntf_rsp_if.sv
// Result channel of the formatter: one ASCII character and a last flag per beat.
// No dependencies.
`default_nettype none

interface ntf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       last;

   modport source (output valid, output char_code, output last, input ready);
   modport sink (input valid, input char_code, input last, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/number_to_text_formatter.sv
// Top level of the number-to-text formatter: APB register file, datapath, result register.
// Depends on ntf_pkg, ntf_req_if, ntf_rsp_if and ntf_seq.
//
//   channel   | direction | beat contents
//   ----------+-----------+-------------------------------------------
//   req_chan  | in        | value (64 bits)
//   rsp_chan  | out       | char_code (8 bits), last (1 bit)
//   APB port  | in/out    | radix, word size, signed, grouping registers
//
// One value at a time. Binary emits one character per word-size bit, hex one per nibble.
// Decimal shifts the value bit by bit through the double-dabble loop, skips the leading
// zeros, then emits the sign and each digit, each digit followed by a comma step or by a check for digits left.
// A stalled result register holds the sequencer on its emit step.
// Reset is synchronous; registers return to hex, 32 bits, unsigned, grouping on.
`default_nettype none

module number_to_text_formatter (
   input  logic                         clock,
   input  logic                         reset,
   ntf_req_if.sink                      req_chan,
   ntf_rsp_if.source                    rsp_chan,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [ntf_pkg::ADDR_W-1:0]   paddr,
   input  logic [ntf_pkg::DATA_W-1:0]   pwdata,
   output logic [ntf_pkg::DATA_W-1:0]   prdata,
   output logic                         pready
);
   import ntf_pkg::*;

   logic [1:0]        radix_ff;
   logic [1:0]        word_size_ff;
   logic              signed_ff;
   logic              group_ff;

   logic [WORD_W-1:0] work_ff, work_in;
   logic [BCD_W-1:0]  bcd_ff, bcd_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [1:0]        mod3_ff, mod3_in;
   logic              neg_ff, neg_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_char_ff, rsp_char_in;
   logic              rsp_last_ff, rsp_last_in;

   ctrl_type          ctrl;
   flags_type         flags;
   logic              slot_free;
   logic              accept;
   logic              emit;
   logic [5:0]        align_shift;
   logic [CNT_W-1:0]  word_bits;
   logic [BCD_W-1:0]  bcd_adj;
   logic [1:0]        mod3_dec;
   logic              csr_write;

   ntf_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl)
   );

   assign pready = 1'b1;
   assign csr_write = psel & penable & pwrite;

   always_comb begin
      unique case (paddr[3:2])
         REG_RADIX:     prdata = {30'b0, radix_ff};
         REG_WORD_SIZE: prdata = {30'b0, word_size_ff};
         REG_SIGNED:    prdata = {31'b0, signed_ff};
         REG_GROUP:     prdata = {31'b0, group_ff};
         default:       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_HEX;
         word_size_ff <= 2'd2;
         signed_ff <= 1'b0;
         group_ff <= 1'b1;
      end else if (csr_write) begin
         unique case (paddr[3:2])
            REG_RADIX:     radix_ff <= pwdata[1:0];
            REG_WORD_SIZE: word_size_ff <= pwdata[1:0];
            REG_SIGNED:    signed_ff <= pwdata[0];
            REG_GROUP:     group_ff <= pwdata[0];
            default:       radix_ff <= radix_ff;
         endcase
      end
   end

   assign req_chan.ready = (ctrl.op == OP_ACCEPT);
   assign accept = req_chan.valid & req_chan.ready;
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;

   assign word_bits = CNT_W'(8) << word_size_ff;
   assign align_shift = 6'(WORD_W - 32'(word_bits));
   assign mod3_dec = (mod3_ff == 2'd0) ? 2'd2 : mod3_ff - 2'd1;

   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         bcd_adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ? bcd_ff[4*i +: 4] + 4'd3
                                                        : bcd_ff[4*i +: 4];
      end
   end

   always_comb begin
      flags.bad_radix = (radix_ff != RADIX_BIN) && (radix_ff != RADIX_DEC)
                        && (radix_ff != RADIX_HEX);
      flags.decimal = (radix_ff == RADIX_DEC);
      flags.more = (cnt_ff != CNT_W'(1));
      flags.lead_zero = (bcd_ff[BCD_W-1 -: 4] == 4'd0) && (cnt_ff != CNT_W'(1));
      flags.comma = group_ff && (cnt_ff != CNT_W'(1)) && (mod3_ff == 2'd0);
      flags.digits_left = (cnt_ff != '0);
      case (ctrl.op)
         OP_ACCEPT:     flags.done = accept;
         OP_EMIT_WORD,
         OP_EMIT_DIGIT,
         OP_EMIT_COMMA: flags.done = slot_free;
         OP_EMIT_SIGN:  flags.done = slot_free || !neg_ff;
         default:       flags.done = 1'b1;
      endcase
   end

   always_comb begin
      work_in = work_ff;
      bcd_in = bcd_ff;
      cnt_in = cnt_ff;
      mod3_in = mod3_ff;
      neg_in = neg_ff;
      emit = 1'b0;
      rsp_char_in = rsp_char_ff;
      rsp_last_in = rsp_last_ff;
      case (ctrl.op)
         OP_ACCEPT: begin
            if (accept) begin
               work_in = req_chan.value << align_shift;
               cnt_in = (radix_ff == RADIX_HEX) ? (word_bits >> 2) : word_bits;
            end
         end
         OP_EMIT_WORD: begin
            if (slot_free) begin
               emit = 1'b1;
               rsp_last_in = (cnt_ff == CNT_W'(1));
               cnt_in = cnt_ff - CNT_W'(1);
               if (radix_ff == RADIX_HEX) begin
                  rsp_char_in = hex_char(work_ff[WORD_W-1 -: 4]);
                  work_in = work_ff << 4;
               end else begin
                  rsp_char_in = work_ff[WORD_W-1] ? CHAR_ONE : CHAR_ZERO;
                  work_in = work_ff << 1;
               end
            end
         end
         OP_NEGATE: begin
            bcd_in = '0;
            neg_in = signed_ff && work_ff[WORD_W-1];
            if (signed_ff && work_ff[WORD_W-1]) begin
               work_in = ~work_ff + WORD_W'(1);
            end
         end
         OP_DABBLE: begin
            bcd_in = {bcd_adj[BCD_W-2:0], work_ff[WORD_W-1]};
            work_in = work_ff << 1;
            cnt_in = cnt_ff - CNT_W'(1);
         end
         OP_DIGITS_INIT: begin
            cnt_in = DIGIT_COUNT;
            mod3_in = TOP_DIGIT_MOD3;
         end
         OP_SKIP: begin
            if (flags.lead_zero) begin
               bcd_in = bcd_ff << 4;
               cnt_in = cnt_ff - CNT_W'(1);
               mod3_in = mod3_dec;
            end
         end
         OP_EMIT_SIGN: begin
            if (slot_free && neg_ff) begin
               emit = 1'b1;
               rsp_char_in = CHAR_MINUS;
               rsp_last_in = 1'b0;
            end
         end
         OP_EMIT_DIGIT: begin
            if (slot_free) begin
               emit = 1'b1;
               rsp_char_in = CHAR_ZERO + {4'b0, bcd_ff[BCD_W-1 -: 4]};
               rsp_last_in = (cnt_ff == CNT_W'(1));
               bcd_in = bcd_ff << 4;
               cnt_in = cnt_ff - CNT_W'(1);
               mod3_in = mod3_dec;
            end
         end
         OP_EMIT_COMMA: begin
            if (slot_free) begin
               emit = 1'b1;
               rsp_char_in = CHAR_COMMA;
               rsp_last_in = 1'b0;
            end
         end
         default: begin
            work_in = work_ff;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      bcd_ff <= bcd_in;
      cnt_ff <= cnt_in;
      mod3_ff <= mod3_in;
      neg_ff <= neg_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.char_code = rsp_char_ff;
   assign rsp_chan.last = rsp_last_ff;

endmodule

`default_nettype wire

FILE: rtl/core/ntf_seq.sv
// Microcode sequencer: step counter, program table lookup and conditional jumps.
// Depends on ntf_pkg for the control word, flag struct and program.
`default_nettype none

module ntf_seq (
   input  logic               clock,
   input  logic               reset,
   input  ntf_pkg::flags_type flags,
   output ntf_pkg::ctrl_type  ctrl
);
   import ntf_pkg::*;

   step_type pc_ff;
   step_type pc_in;
   logic     cond_true;

   assign ctrl = program_word(pc_ff);

   always_comb begin
      case (ctrl.cond)
         C_ALWAYS:      cond_true = 1'b1;
         C_BAD_RADIX:   cond_true = flags.bad_radix;
         C_DECIMAL:     cond_true = flags.decimal;
         C_MORE:        cond_true = flags.more;
         C_LEAD_ZERO:   cond_true = flags.lead_zero;
         C_COMMA:       cond_true = flags.comma;
         C_DIGITS_LEFT: cond_true = flags.digits_left;
         default:       cond_true = 1'b0;
      endcase
   end

   always_comb begin
      pc_in = pc_ff;
      if (flags.done) begin
         pc_in = cond_true ? ctrl.target : pc_ff + step_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= ST_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/ntf_checker.sv
// Port-level assertions on the formatter's result channel, and the bind to the top level.
// Depends on ntf_pkg for character codes and on number_to_text_formatter.
`default_nettype none

module ntf_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_char_code,
   input logic       rsp_last
);
   import ntf_pkg::*;

   logic is_digit;
   logic is_hex_letter;

   assign is_digit = (rsp_char_code >= CHAR_ZERO) && (rsp_char_code <= CHAR_ZERO + 8'd9);
   assign is_hex_letter = (rsp_char_code >= CHAR_ALPHA_BASE + 8'd10)
                          && (rsp_char_code <= CHAR_ALPHA_BASE + 8'd15);

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_char_code) && $stable(rsp_last))
      else $error("result beat changed while stalled");

   a_charset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> is_digit || is_hex_letter || rsp_char_code == CHAR_COMMA
                    || rsp_char_code == CHAR_MINUS)
      else $error("result character outside the text alphabet");

   a_comma_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_char_code == CHAR_COMMA |-> !rsp_last)
      else $error("comma ends the text");

   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_char_code == CHAR_MINUS |-> !rsp_last)
      else $error("minus sign ends the text");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind number_to_text_formatter ntf_checker u_ntf_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_char_code (rsp_chan.char_code),
   .rsp_last      (rsp_chan.last)
);

`default_nettype wire
